// ----- rtl/fnvmix_pkg.sv -----
// Shared constants and combinational functions of the FNV-1a hash with final mix.
package fnvmix_pkg;

	localparam int unsigned HashWidth = 32;
	localparam int unsigned ByteWidth = 8;

	localparam logic [HashWidth-1:0] FNV_PRIME = 32'd16777619;
	localparam logic [HashWidth-1:0] FNV_BASIS = 32'd2166136261;

	localparam int unsigned MIX_SHL_A = 13;
	localparam int unsigned MIX_SHR_A = 7;
	localparam int unsigned MIX_SHL_B = 3;
	localparam int unsigned MIX_SHR_B = 17;
	localparam int unsigned MIX_SHL_C = 5;

	// The prime is 2^24 + 2^8 + 0x93, so the product is a sum of shifted copies.
	function automatic logic [HashWidth-1:0] fnv_step(
		input logic [HashWidth-1:0] h,
		input logic [ByteWidth-1:0] b
	);
		logic [HashWidth-1:0] x;
		x = h ^ {{(HashWidth-ByteWidth){1'b0}}, b};
		return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [HashWidth-1:0] mix_front(input logic [HashWidth-1:0] h);
		logic [HashWidth-1:0] t;
		t = h + (h << MIX_SHL_A);
		t = t ^ (t >> MIX_SHR_A);
		t = t + (t << MIX_SHL_B);
		return t;
	endfunction

	function automatic logic [HashWidth-1:0] mix_back(input logic [HashWidth-1:0] h);
		logic [HashWidth-1:0] t;
		t = h ^ (h >> MIX_SHR_B);
		t = t + (t << MIX_SHL_C);
		return t;
	endfunction

endpackage

// ----- rtl/fnvmix_in_if.sv -----
// Message byte channel: one byte per request with a last-byte flag.
interface fnvmix_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [fnvmix_pkg::ByteWidth-1:0]       data_byte;
	logic                                   last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/fnvmix_out_if.sv -----
// Hash result channel: one finished 32-bit hash per request.
interface fnvmix_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [fnvmix_pkg::HashWidth-1:0]       hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- rtl/fnvmix_core.sv -----
// Running FNV-1a state and the stage that hands a finished message hash to the mixer.
module fnvmix_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fnvmix_pkg::ByteWidth-1:0]  data_byte,
	input  logic                              last_byte,
	output logic                              s1_valid,
	input  logic                              s1_ready,
	output logic [fnvmix_pkg::HashWidth-1:0]  s1_hash
);

	logic [fnvmix_pkg::HashWidth-1:0] hash_q;
	logic [fnvmix_pkg::HashWidth-1:0] hash_next;
	logic [fnvmix_pkg::HashWidth-1:0] hash_s1;
	logic                             valid_s1;
	logic                             accept;

	assign in_ready  = !valid_s1 || s1_ready;
	assign accept    = in_valid && in_ready;
	assign hash_next = fnvmix_pkg::fnv_step(hash_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= fnvmix_pkg::FNV_BASIS;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				// A last byte closes the message and restarts the state at the basis.
				hash_q <= last_byte ? fnvmix_pkg::FNV_BASIS : hash_next;
			end
			if (accept && last_byte) begin
				valid_s1 <= 1'b1;
			end else if (s1_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			hash_s1 <= hash_next;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_hash  = hash_s1;

endmodule

// ----- rtl/fnvmix_mix.sv -----
// Two-stage final avalanche mix; the second stage is the output register.
module fnvmix_mix (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s1_valid,
	output logic                              s1_ready,
	input  logic [fnvmix_pkg::HashWidth-1:0]  s1_hash,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fnvmix_pkg::HashWidth-1:0]  hash_value
);

	logic [fnvmix_pkg::HashWidth-1:0] hash_s2;
	logic                             valid_s2;
	logic [fnvmix_pkg::HashWidth-1:0] hash_q;
	logic                             valid_q;
	logic                             out_room;
	logic                             s2_room;

	assign out_room = !valid_q || out_ready;
	assign s2_room  = !valid_s2 || out_room;
	assign s1_ready = s2_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s2_room) begin
				valid_s2 <= s1_valid;
			end
			if (out_room) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_room && s1_valid) begin
			hash_s2 <= fnvmix_pkg::mix_front(s1_hash);
		end
		if (out_room && valid_s2) begin
			hash_q <= fnvmix_pkg::mix_back(hash_s2);
		end
	end

	assign out_valid  = valid_q;
	assign hash_value = hash_q;

endmodule

// ----- rtl/fnv1a_hash_with_final_mix.sv -----
// Top level of the FNV-1a 32-bit byte-stream hash with a final avalanche mix.
//
// The msg channel takes one message byte per request, with last_byte set on
// the final byte of each message. Every byte updates a running hash that
// starts at the FNV offset basis; the byte marked last closes the message,
// and the hash channel then delivers one 32-bit hash_value for it. Bytes not
// marked last produce no result.
// Throughput is one byte per cycle while msg.ready is high, since each accepted
// byte updates the running hash register directly (xor plus a constant multiply built from shifted adds).
// A result passes through the hand-off stage, which loads at the edge that
// accepted its last byte, and then through two mix stages, the last of which
// is the output register.
// When the receiver stalls, the mix pipeline fills; msg.ready stays high until
// the hand-off stage also holds a waiting hash, so up to three results can be
// buffered while bytes keep flowing.
// Reset clears all valid flags and sets the running hash to the offset basis.
module fnv1a_hash_with_final_mix (
	input  logic         clk,
	input  logic         arst_n,
	fnvmix_in_if.sink    msg,
	fnvmix_out_if.source hash
);

	logic                             s1_valid;
	logic                             s1_ready;
	logic [fnvmix_pkg::HashWidth-1:0] s1_hash;

	fnvmix_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (msg.valid),
		.in_ready  (msg.ready),
		.data_byte (msg.data_byte),
		.last_byte (msg.last_byte),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_hash   (s1_hash)
	);

	fnvmix_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1_ready   (s1_ready),
		.s1_hash    (s1_hash),
		.out_valid  (hash.valid),
		.out_ready  (hash.ready),
		.hash_value (hash.hash_value)
	);

	// A request that carries the last byte always shows up in the hand-off stage.
	a_last_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && msg.last_byte) |=> s1_valid)
		else $error("last byte accepted but no hash handed to the mixer");

	// The byte channel only backs up when the hand-off stage is full and blocked.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!msg.ready |-> (s1_valid && !s1_ready))
		else $error("byte channel stalled without a blocked hand-off stage");

	// The mixer can only refuse a hash while the output holds an untaken result.
	a_mix_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_ready |-> (hash.valid && !hash.ready))
		else $error("mixer refused a hash while the output was free");

	// A blocked hand-off keeps its hash until the mixer takes it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_hash)))
		else $error("hand-off hash changed while stalled");

endmodule
